/* design/assert_macros.svh */
// Assertion helpers shared by the decoder modules.
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ADF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true outside reset.
`define ADF_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* design/adf_pkg.sv */
package adf_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_SHORT     = 3'd0,
    ERR_CHANNEL   = 3'd1,
    ERR_TAG       = 3'd2,
    ERR_NO_INDEX0 = 3'd3,
    ERR_ORDER     = 3'd4,
    ERR_NO_LENGTH = 3'd5,
    ERR_NO_STATUS = 3'd6,
    ERR_NONE      = 3'd7
  } err_t;

  localparam logic [7:0]  TAG_BYTE     = 8'h05;
  localparam logic [15:0] CHANNEL_WORD = 16'h0101;
  localparam logic [2:0]  POS_MAX      = 3'd7;
  localparam logic [16:0] COUNT_MAX    = 17'h1FFFF;

  // Register indexes of the configuration port.
  localparam logic REG_CHANNEL_MODE = 1'b0;

  // What one accepted item leaves for the output side: an optional data
  // byte followed by an optional frame-end result.
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data;
    logic        has_end;
    kind_t       end_kind;
    logic [15:0] status;
    err_t        err;
  } adf_entry_t;

endpackage

/* design/adf_front.sv */
module adf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                func,
  input  logic [7:0]          frame_byte,
  input  logic                frame_end,
  input  logic                channel_mode,
  output logic                push,
  output adf_pkg::adf_entry_t entry
);
  import adf_pkg::*;

  logic [2:0]  header_position, header_position_next;
  err_t        pending_error, pending_error_next;
  logic        frame_dropped, frame_dropped_next;
  logic [15:0] received_index, received_index_next;
  logic [15:0] expected_index, expected_index_next;
  logic        length_known, length_known_next;
  logic [15:0] response_length, response_length_next;
  logic [16:0] payload_count, payload_count_next;
  logic [15:0] status_capture, status_capture_next;

  logic [2:0]  cp;
  logic [2:0]  hdr;
  logic [2:0]  pos_new;
  logic [7:0]  want;
  logic [15:0] index_new;
  logic [16:0] dlen;

  assign cp        = channel_mode ? 3'd2 : 3'd0;
  assign hdr       = 3'(cp + 3'd3 + ((received_index == 16'd0) ? 3'd2 : 3'd0));
  assign pos_new   = (header_position == POS_MAX) ? POS_MAX : 3'(header_position + 3'd1);
  assign want      = (header_position == 3'd0) ? CHANNEL_WORD[15:8] : CHANNEL_WORD[7:0];
  assign index_new = {received_index[15:8], frame_byte};
  assign dlen      = {1'b0, response_length} - 17'd2;

  always_comb begin
    header_position_next = header_position;
    pending_error_next   = pending_error;
    frame_dropped_next   = frame_dropped;
    received_index_next  = received_index;
    expected_index_next  = expected_index;
    length_known_next    = length_known;
    response_length_next = response_length;
    payload_count_next   = payload_count;
    status_capture_next  = status_capture;
    entry                = '0;
    entry.end_kind       = KIND_DATA;
    entry.err            = ERR_SHORT;
    push                 = 1'b0;

    if (accept) begin
      if (func) begin
        header_position_next = '0;
        pending_error_next   = ERR_NONE;
        frame_dropped_next   = 1'b0;
        received_index_next  = '0;
        expected_index_next  = '0;
        length_known_next    = 1'b0;
        response_length_next = '0;
        payload_count_next   = '0;
        status_capture_next  = '0;
      end else begin
        if (!frame_dropped) begin
          if (header_position < cp) begin
            if (frame_byte != want) begin
              pending_error_next = ERR_CHANNEL;
              frame_dropped_next = 1'b1;
            end
          end else if (header_position == cp) begin
            if (frame_byte != TAG_BYTE) begin
              pending_error_next = ERR_TAG;
              frame_dropped_next = 1'b1;
            end
          end else if (header_position == 3'(cp + 3'd1)) begin
            received_index_next = {frame_byte, 8'h00};
          end else if (header_position == 3'(cp + 3'd2)) begin
            received_index_next = index_new;
            if (!length_known && index_new != 16'd0) begin
              pending_error_next = ERR_NO_INDEX0;
              frame_dropped_next = 1'b1;
            end else if (index_new != expected_index) begin
              pending_error_next = ERR_ORDER;
              frame_dropped_next = 1'b1;
            end
          end else if (header_position < hdr && header_position == 3'(cp + 3'd3)) begin
            response_length_next = {frame_byte, 8'h00};
          end else if (header_position < hdr && header_position == 3'(cp + 3'd4)) begin
            response_length_next = {response_length[15:8], frame_byte};
            length_known_next    = 1'b1;
          end else begin
            // Payload: data bytes first, then the two status bytes, then padding.
            if (response_length >= 16'd2) begin
              if (payload_count < dlen) begin
                entry.has_data = 1'b1;
                entry.data     = frame_byte;
              end else if (payload_count == dlen) begin
                status_capture_next = {frame_byte, status_capture[7:0]};
              end else if (payload_count == 17'(dlen + 17'd1)) begin
                status_capture_next = {status_capture[15:8], frame_byte};
              end
            end
            if (payload_count != COUNT_MAX) begin
              payload_count_next = 17'(payload_count + 17'd1);
            end
          end
        end
        header_position_next = pos_new;

        if (frame_end) begin
          if (pos_new < 3'(cp + 3'd3)) begin
            entry.has_end  = 1'b1;
            entry.end_kind = KIND_ERROR;
            entry.err      = ERR_SHORT;
          end else if (frame_dropped_next) begin
            entry.has_end  = 1'b1;
            entry.end_kind = KIND_ERROR;
            entry.err      = pending_error_next;
          end else if (received_index_next == 16'd0 && !length_known_next) begin
            response_length_next = '0;
            entry.has_end        = 1'b1;
            entry.end_kind       = KIND_ERROR;
            entry.err            = ERR_NO_LENGTH;
          end else if (payload_count_next < {1'b0, response_length_next}) begin
            expected_index_next = 16'(expected_index + 16'd1);
          end else begin
            entry.has_end = 1'b1;
            if (response_length_next < 16'd2) begin
              entry.end_kind = KIND_ERROR;
              entry.err      = ERR_NO_STATUS;
            end else begin
              entry.end_kind = KIND_DONE;
              entry.status   = status_capture_next;
            end
            expected_index_next  = '0;
            length_known_next    = 1'b0;
            response_length_next = '0;
            payload_count_next   = '0;
            status_capture_next  = '0;
          end
          header_position_next = '0;
          pending_error_next   = ERR_NONE;
          frame_dropped_next   = 1'b0;
          received_index_next  = '0;
        end
      end
      push = entry.has_data | entry.has_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      pending_error   <= ERR_NONE;
      frame_dropped   <= 1'b0;
      received_index  <= '0;
      expected_index  <= '0;
      length_known    <= 1'b0;
      response_length <= '0;
      payload_count   <= '0;
      status_capture  <= '0;
    end else begin
      header_position <= header_position_next;
      pending_error   <= pending_error_next;
      frame_dropped   <= frame_dropped_next;
      received_index  <= received_index_next;
      expected_index  <= expected_index_next;
      length_known    <= length_known_next;
      response_length <= response_length_next;
      payload_count   <= payload_count_next;
      status_capture  <= status_capture_next;
    end
  end

endmodule

/* design/adf_queue.sv */
`include "assert_macros.svh"

module adf_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  adf_pkg::adf_entry_t wr_entry,
  input  logic                pop,
  output adf_pkg::adf_entry_t rd_entry,
  output logic                full,
  output logic                empty
);
  import adf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  adf_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  `ADF_ASSERT(a_count_bound, (count <= FULL_COUNT), "queue count beyond depth")
  `ADF_NEVER(a_push_full, (push && full && !pop), "item pushed into a full queue")
  `ADF_NEVER(a_pop_empty, (pop && empty), "item popped from an empty queue")

endmodule

/* design/adf_back.sv */
`include "assert_macros.svh"

module adf_back (
  input  logic                clk,
  input  logic                rst,
  input  adf_pkg::adf_entry_t head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [7:0]          data_byte,
  output logic [15:0]         resp_status,
  output logic [2:0]          error_code,
  output logic                last
);
  import adf_pkg::*;

  // Set once the data byte of an entry that also has a frame-end result is gone.
  logic phase, phase_next;
  logic show_end;
  logic fire;

  assign show_end  = !head.has_data || phase;
  assign out_valid = head_valid;
  assign fire      = out_valid && !out_stall;

  always_comb begin
    kind        = KIND_DATA;
    data_byte   = head.data;
    resp_status = '0;
    error_code  = '0;
    last        = !head.has_end;
    if (show_end) begin
      kind        = head.end_kind;
      data_byte   = '0;
      resp_status = head.status;
      error_code  = (head.end_kind == KIND_ERROR) ? head.err : '0;
      last        = 1'b1;
    end
  end

  assign pop = fire && last;

  always_comb begin
    phase_next = phase;
    if (fire) begin
      phase_next = !last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else begin
      phase <= phase_next;
    end
  end

  `ADF_ASSERT(a_phase_entry, (phase |-> head_valid && head.has_data && head.has_end),
    "second half pending on an entry without both results")
  `ADF_ASSERT(a_phase_clear, (pop |=> !phase), "phase left set after an entry retired")
  `ADF_ASSERT(a_valid_content, (out_valid |-> head.has_data || head.has_end),
    "empty entry presented at the output")

endmodule

/* design/apdu_frame_decoder.sv */
// A result is written into the result queue and offered on the output at its head.
// Throughput: one item per cycle while the queue is not full; the header and
// payload logic of the front part is combinational. An item that both delivers a data
// byte and ends a response gives two output results, and the queue absorbs the burst.
// Reset: clears the reassembly session and the current frame, empties the queue
// and sets channel_mode to 1.
module apdu_frame_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] resp_status,
  output logic [2:0]  error_code,
  output logic        last
);
  import adf_pkg::*;

  logic       channel_mode;
  logic       accept;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  adf_entry_t wr_entry;
  adf_entry_t head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHANNEL_MODE) begin
      channel_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_CHANNEL_MODE) ? {31'd0, channel_mode} : 32'd0;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  adf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .func         (func),
    .frame_byte   (frame_byte),
    .frame_end    (frame_end),
    .channel_mode (channel_mode),
    .push         (push),
    .entry        (wr_entry)
  );

  adf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .full     (full),
    .empty    (empty)
  );

  adf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (!empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .data_byte   (data_byte),
    .resp_status (resp_status),
    .error_code  (error_code),
    .last        (last)
  );

endmodule
